[design/rqpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpd_pkg
// Shared widths, register indexes and reset values of the rotation
// quarter-period detector.
// ----------------------------------------------------------------------------
package rqpd_pkg;

    // box coordinate width and derived widths
    localparam int COORD_BITS  = 12;
    localparam int CENTER_BITS = COORD_BITS + 1;
    localparam int ANGLE_BITS  = 12;
    localparam int TIME_BITS   = 32;
    localparam int TIMEOUT_BITS = 16;

    // event history depth, one entry per quarter turn
    localparam int HISTORY_DEPTH = 4;
    localparam int HIST_IDX_BITS = $clog2(HISTORY_DEPTH);

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TRIGGER_LOW  = 3'd0,
        REG_TRIGGER_HIGH = 3'd1,
        REG_REARM_LOW    = 3'd2,
        REG_REARM_HIGH   = 3'd3,
        REG_MARK_LOW     = 3'd4,
        REG_MARK_HIGH    = 3'd5,
        REG_STALE_TIMEOUT = 3'd6
    } cfg_reg_t;

    // register reset values
    localparam logic signed [ANGLE_BITS-1:0] TRIGGER_LOW_RST  = 12'sd870;
    localparam logic signed [ANGLE_BITS-1:0] TRIGGER_HIGH_RST = 12'sd930;
    localparam logic signed [ANGLE_BITS-1:0] REARM_LOW_RST    = 12'sd850;
    localparam logic signed [ANGLE_BITS-1:0] REARM_HIGH_RST   = 12'sd950;
    localparam logic signed [ANGLE_BITS-1:0] MARK_LOW_RST     = 12'sd895;
    localparam logic signed [ANGLE_BITS-1:0] MARK_HIGH_RST    = 12'sd905;
    localparam logic [TIMEOUT_BITS-1:0]      STALE_TIMEOUT_RST = 16'd3000;

endpackage

[design/rotation_quarter_period_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_quarter_period_detector
// Detects quarter turns of a rotating target from per-frame boxes and
// reports event intervals, full-turn periods and a latched marker centre.
// ----------------------------------------------------------------------------
// One item enters per cycle when the output side keeps up. Its result is
// registered as it leaves the input register. An input register feeds
// one pass of compare and squaring logic that also updates the tracking
// state, and the result register holds the answer until it is taken. The
// next item reads the state left by the one before it right after that
// state is written, so items may follow each other in consecutive cycles.
// A stall on the output side holds the result register and then the input
// register.
module rotation_quarter_period_detector
(
    input  logic                                          clk,
    input  logic                                          rst_n,

    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [rqpd_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [rqpd_pkg::CFG_DATA_BITS-1:0]            cfg_data,

    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [rqpd_pkg::COORD_BITS-1:0]               box_left,
    input  logic [rqpd_pkg::COORD_BITS-1:0]               box_top,
    input  logic [rqpd_pkg::COORD_BITS-1:0]               box_width,
    input  logic [rqpd_pkg::COORD_BITS-1:0]               box_height,
    input  logic signed [rqpd_pkg::ANGLE_BITS-1:0]        edge_angle,
    input  logic [rqpd_pkg::TIME_BITS-1:0]                time_ms,

    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic                                          quarter_event,
    output logic [rqpd_pkg::TIME_BITS-1:0]                quarter_interval_ms,
    output logic                                          period_valid,
    output logic [rqpd_pkg::TIME_BITS-1:0]                period_ms,
    output logic [rqpd_pkg::CENTER_BITS-1:0]              marker_x,
    output logic [rqpd_pkg::CENTER_BITS-1:0]              marker_y
);

    import rqpd_pkg::*;

    localparam int SQ_BITS  = 2 * CENTER_BITS;
    localparam int CMP_BITS = SQ_BITS + 3;
    localparam int HSQ_BITS = 2 * COORD_BITS;
    localparam int H9_BITS  = HSQ_BITS + 4;

    // configuration registers
    logic signed [ANGLE_BITS-1:0] trig_low_reg;
    logic signed [ANGLE_BITS-1:0] trig_high_reg;
    logic signed [ANGLE_BITS-1:0] rearm_low_reg;
    logic signed [ANGLE_BITS-1:0] rearm_high_reg;
    logic signed [ANGLE_BITS-1:0] mark_low_reg;
    logic signed [ANGLE_BITS-1:0] mark_high_reg;
    logic [TIMEOUT_BITS-1:0]      stale_timeout_reg;

    // input register
    logic                         s1_valid_reg;
    logic [COORD_BITS-1:0]        s1_left_reg;
    logic [COORD_BITS-1:0]        s1_top_reg;
    logic [COORD_BITS-1:0]        s1_width_reg;
    logic [COORD_BITS-1:0]        s1_height_reg;
    logic signed [ANGLE_BITS-1:0] s1_angle_reg;
    logic [TIME_BITS-1:0]         s1_time_reg;

    // tracking state
    logic                         prev_valid_reg, prev_valid_next;
    logic [CENTER_BITS-1:0]       prev_cx_reg, prev_cx_next;
    logic [CENTER_BITS-1:0]       prev_cy_reg, prev_cy_next;
    logic [H9_BITS-1:0]           prev_h9sq_reg, prev_h9sq_next;
    logic signed [ANGLE_BITS-1:0] prev_angle_reg, prev_angle_next;
    logic [TIME_BITS-1:0]         last_event_time_reg, last_event_time_next;
    logic [TIME_BITS-1:0]         event_times_reg [HISTORY_DEPTH];
    logic [HIST_IDX_BITS-1:0]     count_mod_reg, count_mod_next;
    logic                         hist_nonempty_reg, hist_nonempty_next;
    logic [CENTER_BITS-1:0]       marker_x_reg, marker_x_next;
    logic [CENTER_BITS-1:0]       marker_y_reg, marker_y_next;

    // result register
    logic                         out_valid_reg;
    logic                         event_reg, event_next;
    logic [TIME_BITS-1:0]         interval_reg, interval_next;
    logic                         pvalid_reg, pvalid_next;
    logic [TIME_BITS-1:0]         period_reg, period_next;

    // datapath signals
    logic                         s1_adv;
    logic [CENTER_BITS-1:0]       cx;
    logic [CENTER_BITS-1:0]       cy;
    logic signed [CENTER_BITS:0]  dx;
    logic signed [CENTER_BITS:0]  dy;
    logic signed [2*CENTER_BITS+1:0] dx_sq;
    logic signed [2*CENTER_BITS+1:0] dy_sq;
    logic [SQ_BITS:0]             d2;
    logic [CMP_BITS-1:0]          d2x4;
    logic [HSQ_BITS-1:0]          h_sq;
    logic [TIME_BITS-1:0]         since_last;
    logic                         stale;
    logic [HIST_IDX_BITS-1:0]     count_eff;
    logic                         jump;
    logic                         angle_trig;
    logic                         in_mark;
    logic                         evt;
    logic [HIST_IDX_BITS-1:0]     count_inc;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg      <= TRIGGER_LOW_RST;
            trig_high_reg     <= TRIGGER_HIGH_RST;
            rearm_low_reg     <= REARM_LOW_RST;
            rearm_high_reg    <= REARM_HIGH_RST;
            mark_low_reg      <= MARK_LOW_RST;
            mark_high_reg     <= MARK_HIGH_RST;
            stale_timeout_reg <= STALE_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TRIGGER_LOW:   trig_low_reg      <= cfg_data[ANGLE_BITS-1:0];
                REG_TRIGGER_HIGH:  trig_high_reg     <= cfg_data[ANGLE_BITS-1:0];
                REG_REARM_LOW:     rearm_low_reg     <= cfg_data[ANGLE_BITS-1:0];
                REG_REARM_HIGH:    rearm_high_reg    <= cfg_data[ANGLE_BITS-1:0];
                REG_MARK_LOW:      mark_low_reg      <= cfg_data[ANGLE_BITS-1:0];
                REG_MARK_HIGH:     mark_high_reg     <= cfg_data[ANGLE_BITS-1:0];
                REG_STALE_TIMEOUT: stale_timeout_reg <= cfg_data[TIMEOUT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_left_reg   <= box_left;
            s1_top_reg    <= box_top;
            s1_width_reg  <= box_width;
            s1_height_reg <= box_height;
            s1_angle_reg  <= edge_angle;
            s1_time_reg   <= time_ms;
        end
    end

    // box centre and distance to the previous centre
    assign cx    = CENTER_BITS'({1'b0, s1_left_reg} + {2'b00, s1_width_reg[COORD_BITS-1:1]});
    assign cy    = CENTER_BITS'({1'b0, s1_top_reg} + {2'b00, s1_height_reg[COORD_BITS-1:1]});
    assign dx    = $signed({1'b0, cx}) - $signed({1'b0, prev_cx_reg});
    assign dy    = $signed({1'b0, cy}) - $signed({1'b0, prev_cy_reg});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = {1'b0, dx_sq[SQ_BITS-1:0]} + {1'b0, dy_sq[SQ_BITS-1:0]};
    assign d2x4  = {d2, 2'b00};

    // square of this height; nine times it is kept for the next item
    assign h_sq  = s1_height_reg * s1_height_reg;

    // stale history check ahead of the event test
    assign since_last = s1_time_reg - last_event_time_reg;
    assign stale      = hist_nonempty_reg &&
                        (since_last > {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, stale_timeout_reg});
    assign count_eff  = stale ? '0 : count_mod_reg;

    // event tests
    assign jump       = prev_valid_reg &&
                        (d2x4 > {{(CMP_BITS-H9_BITS){1'b0}}, prev_h9sq_reg});
    assign angle_trig = (s1_angle_reg >= trig_low_reg) && (s1_angle_reg <= trig_high_reg) &&
                        ((prev_angle_reg < rearm_low_reg) || (prev_angle_reg > rearm_high_reg));
    assign in_mark    = (s1_angle_reg >= mark_low_reg) && (s1_angle_reg <= mark_high_reg);
    assign evt        = jump || angle_trig;
    assign count_inc  = count_eff + 1'b1;

    // next state and result
    always_comb
    begin
        prev_valid_next      = 1'b1;
        prev_cx_next         = cx;
        prev_cy_next         = cy;
        prev_h9sq_next       = {h_sq, 3'b000} + {4'b0000, h_sq};
        prev_angle_next      = s1_angle_reg;
        last_event_time_next = last_event_time_reg;
        count_mod_next       = count_eff;
        hist_nonempty_next   = hist_nonempty_reg && !stale;
        marker_x_next        = marker_x_reg;
        marker_y_next        = marker_y_reg;
        event_next           = evt;
        interval_next        = '0;
        pvalid_next          = 1'b0;
        period_next          = '0;
        if (evt)
        begin
            interval_next        = since_last;
            last_event_time_next = s1_time_reg;
            count_mod_next       = count_inc;
            hist_nonempty_next   = 1'b1;
            // a full history wraps to the oldest entry, which is slot zero
            if (count_inc == '0)
            begin
                pvalid_next = 1'b1;
                period_next = s1_time_reg - event_times_reg[0];
            end
            if (in_mark)
            begin
                marker_x_next = cx;
                marker_y_next = cy;
            end
        end
    end

    // tracking state and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg      <= 1'b0;
            prev_cx_reg         <= '0;
            prev_cy_reg         <= '0;
            prev_h9sq_reg       <= '0;
            prev_angle_reg      <= '0;
            last_event_time_reg <= '0;
            count_mod_reg       <= '0;
            hist_nonempty_reg   <= 1'b0;
            marker_x_reg        <= '0;
            marker_y_reg        <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                prev_valid_reg      <= prev_valid_next;
                prev_cx_reg         <= prev_cx_next;
                prev_cy_reg         <= prev_cy_next;
                prev_h9sq_reg       <= prev_h9sq_next;
                prev_angle_reg      <= prev_angle_next;
                last_event_time_reg <= last_event_time_next;
                count_mod_reg       <= count_mod_next;
                hist_nonempty_reg   <= hist_nonempty_next;
                marker_x_reg        <= marker_x_next;
                marker_y_reg        <= marker_y_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // event history and result payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (evt)
            begin
                event_times_reg[count_eff] <= s1_time_reg;
            end
            event_reg    <= event_next;
            interval_reg <= interval_next;
            pvalid_reg   <= pvalid_next;
            period_reg   <= period_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign quarter_event       = event_reg;
    assign quarter_interval_ms = interval_reg;
    assign period_valid        = pvalid_reg;
    assign period_ms           = period_reg;
    assign marker_x            = marker_x_reg;
    assign marker_y            = marker_y_reg;

    // a full-turn period only comes with an event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pvalid_reg |-> event_reg)
        else $error("period reported without an event");

    // an empty history holds no event count
    assert property (@(posedge clk) disable iff (!rst_n)
        !hist_nonempty_reg |-> count_mod_reg == '0)
        else $error("event count set while history empty");

    // an item leaving the input register lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("item lost between input and result register");

    // an accepted item is held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted item not captured");

    // the first item after reset sees no previous box
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !prev_valid_reg |-> !jump)
        else $error("jump detected without a previous box");

endmodule
